/* rtl/fcsg_pkg.sv */
package fcsg_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH    = CFG_IDX_W'(1);

  typedef struct packed {
    logic [11:0] center_x;
    logic [11:0] center_y;
    logic [5:0]  radius;
    logic [31:0] color;
  } fcsg_in_t;

  typedef struct packed {
    logic [31:0] start_address;
    logic [6:0]  pixel_count;
    logic [31:0] span_color;
    logic        last_span;
  } fcsg_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQRT,
    ST_MUL,
    ST_EMIT0,
    ST_EMIT1
  } fcsg_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_cmd;
    logic start_sqrt;
    logic mul_en;
    logic emit0;
    logic emit1;
    logic next_dy;
  } fcsg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cmd_zero;
    logic sqrt_done;
    logic last_dy;
    logic out_free;
  } fcsg_sts_t;

endpackage

/* rtl/filled_circle_span_generator.sv */
// Filled-circle span generator: one circle request in, 2*r span requests out.
// Per row pair: start the bit-serial square root (ST_LOAD), wait for it (ST_SQRT),
// form the addresses (ST_MUL), emit two spans (ST_EMIT0, ST_EMIT1). A new circle is
// taken only after the final span of the last one has been emitted.
// Radius zero is taken and gives nothing. Output stalls hold the emit states.
// Reset (rst_n low, synchronous): base and pitch read 0, controller idle, no span pending.
module filled_circle_span_generator
  import fcsg_pkg::*;
#(
  parameter int unsigned MAX_RADIUS      = 32,
  parameter int unsigned BYTES_PER_PIXEL = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fcsg_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fcsg_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  fcsg_cmd_t cmd;
  fcsg_sts_t sts;

  // Register writes are taken at once, in any cycle
  assign cfg_ready = 1'b1;

  // Controller: walks dy from 1 to r, one root then two span requests per step
  fcsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Datapath: request registers, iterative square root, address arithmetic
  // and the output register that parts the result side from the work
  fcsg_dp #(
    .MAX_RADIUS      (MAX_RADIUS),
    .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .sts       (sts)
  );

  // Emit only into a free output slot
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit0 || cmd.emit1) |-> sts.out_free)
    else $error("span emitted over a pending span");

  // A circle with non-zero radius holds the input side off the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.radius != '0)) |=> !in_ready)
    else $error("input taken again while a circle is in progress");

  // Drop back to idle right after the final span of a circle
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit1 && sts.last_dy) |=> (in_ready && out_valid && out_data.last_span))
    else $error("final span did not return the block to idle");

  // The root unit is never left running while the block is idle
  a_sqrt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> sts.sqrt_done)
    else $error("square root busy while idle");

endmodule

/* rtl/fcsg_sqrt.sv */
module fcsg_sqrt
  import fcsg_pkg::*;
#(
  parameter int unsigned RW = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*RW-1:0] operand,
  output logic [RW-1:0]   root,
  output logic            done
);

  localparam int unsigned SQW = 2 * RW;
  localparam int unsigned CW  = $clog2(RW + 1);

  logic [SQW-1:0] val_r, val_nxt;
  logic [RW+1:0]  rem_r, rem_nxt;
  logic [RW-1:0]  root_r, root_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  logic [RW+1:0]  rem_sh;
  logic [RW+1:0]  trial;

  // One root bit per cycle, restoring form
  always_comb begin
    rem_sh   = {rem_r[RW-1:0], val_r[SQW-1:SQW-2]};
    trial    = {root_r, 2'b01};
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      val_nxt  = operand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CW'(RW);
    end else if (cnt_r != '0) begin
      val_nxt = {val_r[SQW-3:0], 2'b00};
      cnt_nxt = cnt_r - CW'(1);
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign root = root_r;
  assign done = (cnt_r == '0);

endmodule

/* rtl/fcsg_dp.sv */
module fcsg_dp
  import fcsg_pkg::*;
#(
  parameter int unsigned MAX_RADIUS      = 32,
  parameter int unsigned BYTES_PER_PIXEL = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fcsg_cmd_t            cmd,
  input  fcsg_in_t             in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output fcsg_out_t            out_data,
  output fcsg_sts_t            sts
);

  localparam int unsigned RW  = (MAX_RADIUS < 2) ? 2 : $clog2(MAX_RADIUS + 1);
  localparam int unsigned SQW = 2 * RW;
  localparam int unsigned BW  = $clog2(BYTES_PER_PIXEL + 1);
  localparam int unsigned XOW = 13 + BW + 1;

  logic [31:0]   base_r;
  logic [15:0]   pitch_r;
  logic [11:0]   cx_r;
  logic [11:0]   cy_r;
  logic [RW-1:0] r_r, r_nxt;
  logic [31:0]   color_r;
  logic [RW-1:0] dy_r, dy_nxt;
  logic [RW-1:0] dx_r;
  logic [31:0]   prod0_r, prod1_r, xb_r;
  logic          out_valid_r, out_valid_nxt;
  fcsg_out_t     out_r, out_nxt;

  logic [RW:0]         twice_less;
  logic [2*RW:0]       v_full;
  logic [RW-1:0]       root;
  logic                sqrt_done;
  logic signed [13:0]  row0_s, row1_s;
  logic signed [16:0]  pitch_s;
  logic signed [30:0]  p0, p1;
  logic signed [12:0]  x_s;
  logic signed [XOW-1:0] xo;
  logic [6:0]          pix_cnt;
  logic                out_free;

  // Saturate the radius to the largest the block handles
  always_comb begin
    if (32'(in_data.radius) > MAX_RADIUS) begin
      r_nxt = RW'(MAX_RADIUS);
    end else begin
      r_nxt = RW'(in_data.radius);
    end
  end

  always_comb begin
    dy_nxt = dy_r;
    if (cmd.load_cmd) begin
      dy_nxt = RW'(1);
    end else if (cmd.next_dy) begin
      dy_nxt = dy_r + RW'(1);
    end
  end

  // Square-root operand dy*(2r-dy), at most r*r
  assign twice_less = {r_r, 1'b0} - {1'b0, dy_r};
  assign v_full     = {{(RW + 1){1'b0}}, dy_r} * {{RW{1'b0}}, twice_less};

  fcsg_sqrt #(.RW(RW)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.start_sqrt),
    .operand (v_full[SQW-1:0]),
    .root    (root),
    .done    (sqrt_done)
  );

  // Row offsets and column offset, signed so that negative rows wrap
  assign row0_s  = $signed(14'(cy_r)) + $signed(14'(r_r)) - $signed(14'(dy_r));
  assign row1_s  = $signed(14'(cy_r)) - $signed(14'(r_r)) + $signed(14'(dy_r));
  assign pitch_s = $signed({1'b0, pitch_r});
  assign p0      = 31'(row0_s) * 31'(pitch_s);
  assign p1      = 31'(row1_s) * 31'(pitch_s);
  assign x_s     = $signed({1'b0, cx_r}) - $signed(13'(root));
  assign xo      = XOW'(x_s) * XOW'($signed({1'b0, BW'(BYTES_PER_PIXEL)}));

  assign pix_cnt  = 7'({dx_r, 1'b1});
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit0 || cmd.emit1) begin
      out_valid_nxt         = 1'b1;
      out_nxt.start_address = xb_r + (cmd.emit1 ? prod1_r : prod0_r);
      out_nxt.pixel_count   = pix_cnt;
      out_nxt.span_color    = color_r;
      out_nxt.last_span     = cmd.emit1 && (dy_r == r_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cmd) begin
      cx_r    <= in_data.center_x;
      cy_r    <= in_data.center_y;
      r_r     <= r_nxt;
      color_r <= in_data.color;
    end
    dy_r <= dy_nxt;
    if (cmd.mul_en) begin
      dx_r    <= root;
      prod0_r <= {p0[30], p0};
      prod1_r <= {p1[30], p1};
      xb_r    <= base_r + 32'(xo);
    end
    out_r <= out_nxt;
    if (!rst_n) begin
      base_r      <= '0;
      pitch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_ADDRESS: base_r  <= cfg_data;
          REG_ROW_PITCH:    pitch_r <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  assign sts.cmd_zero  = (in_data.radius == '0);
  assign sts.sqrt_done = sqrt_done;
  assign sts.last_dy   = (dy_r == r_r);
  assign sts.out_free  = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/fcsg_ctrl.sv */
module fcsg_ctrl
  import fcsg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  fcsg_sts_t sts,
  output logic      in_ready,
  output fcsg_cmd_t cmd
);

  fcsg_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !sts.cmd_zero) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (sts.sqrt_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_EMIT0;
      ST_EMIT0: begin
        if (sts.out_free) begin
          state_nxt = ST_EMIT1;
        end
      end
      ST_EMIT1: begin
        if (sts.out_free) begin
          state_nxt = sts.last_dy ? ST_IDLE : ST_LOAD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_cmd = in_valid;
      end
      ST_LOAD:  cmd.start_sqrt = 1'b1;
      ST_SQRT:  ;
      ST_MUL:   cmd.mul_en = 1'b1;
      ST_EMIT0: cmd.emit0 = sts.out_free;
      ST_EMIT1: begin
        cmd.emit1   = sts.out_free;
        cmd.next_dy = sts.out_free && !sts.last_dy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
